/* hw/rtl/packed_vq_code_decoder_macros.svh */
// Assertion helpers for the packed code decoder.
// Each macro needs clk and rst in scope.
`ifndef PACKED_VQ_CODE_DECODER_MACROS_SVH
`define PACKED_VQ_CODE_DECODER_MACROS_SVH

// Same-cycle implication, off while in reset.
`define PVQCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define PVQCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pvqcd_pkg.sv */
`timescale 1ns / 1ps

package pvqcd_pkg;

  // Store sizes
  localparam int CODE_STORE_BYTES = 65536;
  localparam int CODEBOOK_ENTRIES = 256;
  localparam int CS_ADDR_W        = $clog2(CODE_STORE_BYTES);
  localparam int BANK_DEPTH       = CODE_STORE_BYTES / 2;
  localparam int BANK_ADDR_W      = CS_ADDR_W - 1;
  localparam int CB_ADDR_W        = $clog2(CODEBOOK_ENTRIES);

  // Field widths
  localparam int FUNC_W    = 2;
  localparam int WADDR_W   = 16;
  localparam int WORD_W    = 32;
  localparam int EXPERT_W  = 10;
  localparam int DIM_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int CODE_W    = 8;
  localparam int WSEL_W    = 2;
  localparam int SHIFT_W   = 3;
  localparam int CB_DATA_W = 2 * WORD_W;

  // Index arithmetic widths
  localparam int RP_W       = 2 * DIM_W;
  localparam int ERP_W      = EXPERT_W + RP_W;
  localparam int BASE_W     = RP_W + 1;
  localparam int LIN_W      = ERP_W + 1;
  localparam int BOFF_W     = LIN_W + SHIFT_W;
  localparam int BYTE_OFF_W = BOFF_W - SHIFT_W;
  localparam int CMD_ADDR_W = (CS_ADDR_W > WADDR_W) ? CS_ADDR_W : WADDR_W;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_EXPERTS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_PAIRS    = 2'd3;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_WR_CODE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_CB   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DECODE  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PAST  = 2'd2;

  // Code width selects
  localparam logic [WSEL_W-1:0] WSEL_4 = 2'd0;
  localparam logic [WSEL_W-1:0] WSEL_6 = 2'd1;
  localparam logic [WSEL_W-1:0] WSEL_8 = 2'd2;

  localparam logic [WSEL_W-1:0] WSEL_RESET = WSEL_8;

  typedef enum logic [1:0] {
    OP_WR_CODE,
    OP_WR_CB,
    OP_DECODE,
    OP_REPLY
  } op_t;

  typedef struct packed {
    logic [WSEL_W-1:0]   wsel;
    logic [EXPERT_W-1:0] num_experts;
    logic [DIM_W-1:0]    num_rows;
    logic [DIM_W-1:0]    num_pairs;
  } cfg_t;

  typedef struct packed {
    op_t                   op;
    logic [STATUS_W-1:0]   status;
    logic [CMD_ADDR_W-1:0] addr;
    logic [SHIFT_W-1:0]    shift;
    logic [WSEL_W-1:0]     wsel;
    logic [WORD_W-1:0]     re;
    logic [WORD_W-1:0]     im;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [3:0] code_bits(input logic [WSEL_W-1:0] wsel);
    logic [3:0] bits;
    unique case (wsel)
      WSEL_4:  bits = 4'd4;
      WSEL_6:  bits = 4'd6;
      default: bits = 4'd8;
    endcase
    return bits;
  endfunction

  function automatic logic [CODE_W-1:0] code_mask(input logic [WSEL_W-1:0] wsel);
    logic [CODE_W-1:0] mask;
    unique case (wsel)
      WSEL_4:  mask = 8'h0F;
      WSEL_6:  mask = 8'h3F;
      default: mask = 8'hFF;
    endcase
    return mask;
  endfunction

endpackage

/* hw/rtl/pvqcd_ram.sv */
`timescale 1ns / 1ps

module pvqcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/pvqcd_front.sv */
`timescale 1ns / 1ps

module pvqcd_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [pvqcd_pkg::FUNC_W-1:0]      func,
  input  logic [pvqcd_pkg::WADDR_W-1:0]     write_addr,
  input  logic [pvqcd_pkg::WORD_W-1:0]      write_re,
  input  logic [pvqcd_pkg::WORD_W-1:0]      write_im,
  input  logic [pvqcd_pkg::EXPERT_W-1:0]    expert_index,
  input  logic [pvqcd_pkg::DIM_W-1:0]       row_index,
  input  logic [pvqcd_pkg::DIM_W-1:0]       pair_index,
  input  pvqcd_pkg::cfg_t                   cfg,
  input  pvqcd_pkg::q_stat_t                q_stat,
  output logic                              q_push,
  output pvqcd_pkg::cmd_t                   q_cmd
);

  logic adv;

  // Stage 1: captured item
  logic                               s1_valid;
  logic [pvqcd_pkg::FUNC_W-1:0]       s1_func;
  logic [pvqcd_pkg::WADDR_W-1:0]      s1_waddr;
  logic [pvqcd_pkg::WORD_W-1:0]       s1_re;
  logic [pvqcd_pkg::WORD_W-1:0]       s1_im;
  logic [pvqcd_pkg::EXPERT_W-1:0]     s1_e;
  logic [pvqcd_pkg::DIM_W-1:0]        s1_r;
  logic [pvqcd_pkg::DIM_W-1:0]        s1_p;

  // Stage 2: products
  logic                               s2_valid;
  pvqcd_pkg::op_t                     s2_op;
  logic [pvqcd_pkg::STATUS_W-1:0]     s2_status;
  logic [pvqcd_pkg::WADDR_W-1:0]      s2_waddr;
  logic [pvqcd_pkg::WORD_W-1:0]       s2_re;
  logic [pvqcd_pkg::WORD_W-1:0]       s2_im;
  logic [pvqcd_pkg::EXPERT_W-1:0]     s2_e;
  logic [pvqcd_pkg::DIM_W-1:0]        s2_p;
  logic [pvqcd_pkg::RP_W-1:0]         s2_rp;
  logic [pvqcd_pkg::RP_W-1:0]         s2_rowp;

  // Stage 3: expert term and row base
  logic                               s3_valid;
  pvqcd_pkg::op_t                     s3_op;
  logic [pvqcd_pkg::STATUS_W-1:0]     s3_status;
  logic [pvqcd_pkg::WADDR_W-1:0]      s3_waddr;
  logic [pvqcd_pkg::WORD_W-1:0]       s3_re;
  logic [pvqcd_pkg::WORD_W-1:0]       s3_im;
  logic [pvqcd_pkg::ERP_W-1:0]        s3_erp;
  logic [pvqcd_pkg::BASE_W-1:0]       s3_base;

  // Stage 4: linear index
  logic                               s4_valid;
  pvqcd_pkg::op_t                     s4_op;
  logic [pvqcd_pkg::STATUS_W-1:0]     s4_status;
  logic [pvqcd_pkg::WADDR_W-1:0]      s4_waddr;
  logic [pvqcd_pkg::WORD_W-1:0]       s4_re;
  logic [pvqcd_pkg::WORD_W-1:0]       s4_im;
  logic [pvqcd_pkg::LIN_W-1:0]        s4_lin;

  pvqcd_pkg::op_t                     s1_op;
  logic [pvqcd_pkg::STATUS_W-1:0]     s1_status;
  logic                               s1_in_range;

  logic [pvqcd_pkg::BOFF_W-1:0]       lin_ext;
  logic [pvqcd_pkg::BOFF_W-1:0]       bit_off;
  logic [pvqcd_pkg::BYTE_OFF_W-1:0]   byte_off;
  logic [pvqcd_pkg::SHIFT_W-1:0]      bit_shift;
  logic                               past_first;
  logic                               past_second;
  logic                               straddle;

  // Advance unless the last stage holds an item the queue cannot take
  assign adv       = !s4_valid || !q_stat.full;
  assign req_stall = !adv;
  assign q_push    = s4_valid && !q_stat.full;

  // Classify the item
  assign s1_in_range = (s1_e < cfg.num_experts) && (s1_r < cfg.num_rows) &&
                       (s1_p < cfg.num_pairs);

  always_comb begin
    s1_op     = pvqcd_pkg::OP_REPLY;
    s1_status = pvqcd_pkg::ST_OK;
    unique case (s1_func)
      pvqcd_pkg::FUNC_WR_CODE: begin
        if (32'(s1_waddr) < 32'(pvqcd_pkg::CODE_STORE_BYTES)) begin
          s1_op = pvqcd_pkg::OP_WR_CODE;
        end else begin
          s1_status = pvqcd_pkg::ST_RANGE;
        end
      end
      pvqcd_pkg::FUNC_WR_CB: begin
        if (32'(s1_waddr) < 32'(pvqcd_pkg::CODEBOOK_ENTRIES)) begin
          s1_op = pvqcd_pkg::OP_WR_CB;
        end else begin
          s1_status = pvqcd_pkg::ST_RANGE;
        end
      end
      pvqcd_pkg::FUNC_DECODE: begin
        if (s1_in_range) begin
          s1_op = pvqcd_pkg::OP_DECODE;
        end else begin
          s1_status = pvqcd_pkg::ST_RANGE;
        end
      end
      default: begin
        s1_op     = pvqcd_pkg::OP_REPLY;
        s1_status = pvqcd_pkg::ST_OK;
      end
    endcase
  end

  // Scale linear index by code width, split into byte and bit
  assign lin_ext = pvqcd_pkg::BOFF_W'(s4_lin);

  always_comb begin
    unique case (cfg.wsel)
      pvqcd_pkg::WSEL_4: bit_off = lin_ext << 2;
      pvqcd_pkg::WSEL_6: bit_off = (lin_ext << 2) + (lin_ext << 1);
      default:           bit_off = lin_ext << 3;
    endcase
  end

  assign byte_off    = bit_off[pvqcd_pkg::BOFF_W-1:pvqcd_pkg::SHIFT_W];
  assign bit_shift   = bit_off[pvqcd_pkg::SHIFT_W-1:0];
  assign past_first  = byte_off >= pvqcd_pkg::BYTE_OFF_W'(pvqcd_pkg::CODE_STORE_BYTES);
  assign past_second = byte_off >= pvqcd_pkg::BYTE_OFF_W'(pvqcd_pkg::CODE_STORE_BYTES - 1);
  assign straddle    = (5'(pvqcd_pkg::code_bits(cfg.wsel)) + 5'(bit_shift)) > 5'd8;

  always_comb begin
    q_cmd.op     = s4_op;
    q_cmd.status = s4_status;
    q_cmd.addr   = pvqcd_pkg::CMD_ADDR_W'(s4_waddr);
    q_cmd.shift  = bit_shift;
    q_cmd.wsel   = cfg.wsel;
    q_cmd.re     = s4_re;
    q_cmd.im     = s4_im;
    if (s4_op == pvqcd_pkg::OP_DECODE) begin
      q_cmd.addr = pvqcd_pkg::CMD_ADDR_W'(byte_off[pvqcd_pkg::CS_ADDR_W-1:0]);
      if (past_first || (straddle && past_second)) begin
        q_cmd.op     = pvqcd_pkg::OP_REPLY;
        q_cmd.status = pvqcd_pkg::ST_PAST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= req_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func  <= func;
      s1_waddr <= write_addr;
      s1_re    <= write_re;
      s1_im    <= write_im;
      s1_e     <= expert_index;
      s1_r     <= row_index;
      s1_p     <= pair_index;

      s2_op     <= s1_op;
      s2_status <= s1_status;
      s2_waddr  <= s1_waddr;
      s2_re     <= s1_re;
      s2_im     <= s1_im;
      s2_e      <= s1_e;
      s2_p      <= s1_p;
      s2_rp     <= pvqcd_pkg::RP_W'(cfg.num_rows) * pvqcd_pkg::RP_W'(cfg.num_pairs);
      s2_rowp   <= pvqcd_pkg::RP_W'(s1_r) * pvqcd_pkg::RP_W'(cfg.num_pairs);

      s3_op     <= s2_op;
      s3_status <= s2_status;
      s3_waddr  <= s2_waddr;
      s3_re     <= s2_re;
      s3_im     <= s2_im;
      s3_erp    <= pvqcd_pkg::ERP_W'(s2_e) * pvqcd_pkg::ERP_W'(s2_rp);
      s3_base   <= pvqcd_pkg::BASE_W'(s2_rowp) + pvqcd_pkg::BASE_W'(s2_p);

      s4_op     <= s3_op;
      s4_status <= s3_status;
      s4_waddr  <= s3_waddr;
      s4_re     <= s3_re;
      s4_im     <= s3_im;
      s4_lin    <= pvqcd_pkg::LIN_W'(s3_erp) + pvqcd_pkg::LIN_W'(s3_base);
    end
  end

endmodule

/* hw/rtl/pvqcd_queue.sv */
`timescale 1ns / 1ps

module pvqcd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pvqcd_pkg::cmd_t    push_cmd,
  input  logic               pop,
  output pvqcd_pkg::cmd_t    head,
  output pvqcd_pkg::q_stat_t stat
);

  pvqcd_pkg::cmd_t                 ent [pvqcd_pkg::QUEUE_DEPTH];
  logic [pvqcd_pkg::QPTR_W-1:0]    wr_ptr;
  logic [pvqcd_pkg::QPTR_W-1:0]    rd_ptr;
  logic [pvqcd_pkg::QCNT_W-1:0]    count;

  assign head       = ent[rd_ptr];
  assign stat.full  = count == pvqcd_pkg::QCNT_W'(pvqcd_pkg::QUEUE_DEPTH);
  assign stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* hw/rtl/pvqcd_back.sv */
`timescale 1ns / 1ps

module pvqcd_back (
  input  logic                            clk,
  input  logic                            rst,
  input  pvqcd_pkg::cmd_t                 head,
  input  pvqcd_pkg::q_stat_t              q_stat,
  output logic                            q_pop,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [pvqcd_pkg::STATUS_W-1:0]  status,
  output logic [pvqcd_pkg::CODE_W-1:0]    code_value,
  output logic [pvqcd_pkg::WORD_W-1:0]    centroid_re,
  output logic [pvqcd_pkg::WORD_W-1:0]    centroid_im
);

  logic adv;

  logic [pvqcd_pkg::BANK_ADDR_W-1:0] head_idx;
  logic                              even_we;
  logic                              odd_we;
  logic [pvqcd_pkg::BANK_ADDR_W-1:0] even_raddr;
  logic [pvqcd_pkg::CODE_W-1:0]      even_rdata;
  logic [pvqcd_pkg::CODE_W-1:0]      odd_rdata;

  // Stage b1: code bytes come back
  logic                              b1_valid;
  pvqcd_pkg::cmd_t                   b1_cmd;
  logic [pvqcd_pkg::CODE_W-1:0]      b1_lo;
  logic [pvqcd_pkg::CODE_W-1:0]      b1_hi;
  logic [2*pvqcd_pkg::CODE_W-1:0]    b1_pair;
  logic [2*pvqcd_pkg::CODE_W-1:0]    b1_shifted;
  logic [pvqcd_pkg::CODE_W-1:0]      b1_code;
  logic                              b1_code_ok;
  logic                              cb_we;

  // Stage b2: centroid comes back
  logic                              b2_valid;
  pvqcd_pkg::op_t                    b2_op;
  logic [pvqcd_pkg::STATUS_W-1:0]    b2_status;
  logic [pvqcd_pkg::CODE_W-1:0]      b2_code;
  logic [pvqcd_pkg::CB_DATA_W-1:0]   cb_rdata;
  logic                              b2_hit;

  // Whole back end moves together when the result register is free
  assign adv   = !rsp_valid || !rsp_stall;
  assign q_pop = adv && !q_stat.empty;

  // Code store is split into even and odd byte banks so a straddling code
  // reads both bytes in the same cycle
  assign head_idx   = head.addr[pvqcd_pkg::CS_ADDR_W-1:1];
  assign even_raddr = head.addr[0] ? head_idx + 1'b1 : head_idx;
  assign even_we    = q_pop && (head.op == pvqcd_pkg::OP_WR_CODE) && !head.addr[0];
  assign odd_we     = q_pop && (head.op == pvqcd_pkg::OP_WR_CODE) && head.addr[0];

  pvqcd_ram #(
    .WIDTH (pvqcd_pkg::CODE_W),
    .DEPTH (pvqcd_pkg::BANK_DEPTH)
  ) u_even_bank (
    .clk   (clk),
    .we    (even_we),
    .waddr (head_idx),
    .wdata (head.re[pvqcd_pkg::CODE_W-1:0]),
    .re    (adv),
    .raddr (even_raddr),
    .rdata (even_rdata)
  );

  pvqcd_ram #(
    .WIDTH (pvqcd_pkg::CODE_W),
    .DEPTH (pvqcd_pkg::BANK_DEPTH)
  ) u_odd_bank (
    .clk   (clk),
    .we    (odd_we),
    .waddr (head_idx),
    .wdata (head.re[pvqcd_pkg::CODE_W-1:0]),
    .re    (adv),
    .raddr (head_idx),
    .rdata (odd_rdata)
  );

  // Extract the code
  assign b1_lo      = b1_cmd.addr[0] ? odd_rdata : even_rdata;
  assign b1_hi      = b1_cmd.addr[0] ? even_rdata : odd_rdata;
  assign b1_pair    = {b1_hi, b1_lo};
  assign b1_shifted = b1_pair >> b1_cmd.shift;
  assign b1_code    = b1_shifted[pvqcd_pkg::CODE_W-1:0] & pvqcd_pkg::code_mask(b1_cmd.wsel);
  assign b1_code_ok = 32'(b1_code) < 32'(pvqcd_pkg::CODEBOOK_ENTRIES);
  assign cb_we      = adv && b1_valid && (b1_cmd.op == pvqcd_pkg::OP_WR_CB);

  pvqcd_ram #(
    .WIDTH (pvqcd_pkg::CB_DATA_W),
    .DEPTH (pvqcd_pkg::CODEBOOK_ENTRIES)
  ) u_codebook (
    .clk   (clk),
    .we    (cb_we),
    .waddr (b1_cmd.addr[pvqcd_pkg::CB_ADDR_W-1:0]),
    .wdata ({b1_cmd.re, b1_cmd.im}),
    .re    (adv),
    .raddr (b1_code[pvqcd_pkg::CB_ADDR_W-1:0]),
    .rdata (cb_rdata)
  );

  assign b2_hit = (b2_op == pvqcd_pkg::OP_DECODE) && (b2_status == pvqcd_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      b1_valid  <= !q_stat.empty;
      b2_valid  <= b1_valid;
      rsp_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_cmd  <= head;
      b2_op   <= b1_cmd.op;
      b2_code <= b1_code;
      if ((b1_cmd.op == pvqcd_pkg::OP_DECODE) && !b1_code_ok) begin
        b2_status <= pvqcd_pkg::ST_RANGE;
      end else begin
        b2_status <= b1_cmd.status;
      end
      status      <= b2_status;
      code_value  <= b2_hit ? b2_code : '0;
      centroid_re <= b2_hit ? cb_rdata[pvqcd_pkg::CB_DATA_W-1:pvqcd_pkg::WORD_W] : '0;
      centroid_im <= b2_hit ? cb_rdata[pvqcd_pkg::WORD_W-1:0] : '0;
    end
  end

endmodule

/* hw/rtl/packed_vq_code_decoder.sv */
// Channel  Handshake             Beat contents
// req      req_valid/req_stall   func, write_addr, write_re, write_im,
//                                expert_index, row_index, pair_index
// rsp      rsp_valid/rsp_stall   status, code_value, centroid_re, centroid_im
// cfg      cfg_we                cfg_index, cfg_data
//
// One beat in and one beat out per cycle when neither side stalls.
// A result passes through 4 front stages, 1 entry in the queue, 2 memory
// stages and the result register; the rate is set by the single read per
// cycle on each code-store bank and on the codebook.
// Reset clears the pipelines and the queue and loads the register defaults;
// both stores are left as they are.
// A stall on rsp freezes the back end; the queue then fills and req_stall rises.
`timescale 1ns / 1ps
`include "packed_vq_code_decoder_macros.svh"

module packed_vq_code_decoder (
  input  logic                               clk,
  input  logic                               rst,

  input  logic                               cfg_we,
  input  logic [pvqcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pvqcd_pkg::CFG_DATA_W-1:0]   cfg_data,

  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [pvqcd_pkg::FUNC_W-1:0]       func,
  input  logic [pvqcd_pkg::WADDR_W-1:0]      write_addr,
  input  logic [pvqcd_pkg::WORD_W-1:0]       write_re,
  input  logic [pvqcd_pkg::WORD_W-1:0]       write_im,
  input  logic [pvqcd_pkg::EXPERT_W-1:0]     expert_index,
  input  logic [pvqcd_pkg::DIM_W-1:0]        row_index,
  input  logic [pvqcd_pkg::DIM_W-1:0]        pair_index,

  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic [pvqcd_pkg::STATUS_W-1:0]     status,
  output logic [pvqcd_pkg::CODE_W-1:0]       code_value,
  output logic [pvqcd_pkg::WORD_W-1:0]       centroid_re,
  output logic [pvqcd_pkg::WORD_W-1:0]       centroid_im
);

  pvqcd_pkg::cfg_t    cfg;
  pvqcd_pkg::q_stat_t q_stat;
  pvqcd_pkg::cmd_t    q_cmd;
  pvqcd_pkg::cmd_t    q_head;
  logic               q_push;
  logic               q_pop;

  // Configuration registers; the user writes them only while the block is idle (not enforced)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wsel        <= pvqcd_pkg::WSEL_RESET;
      cfg.num_experts <= '0;
      cfg.num_rows    <= '0;
      cfg.num_pairs   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pvqcd_pkg::REG_WIDTH_SELECT: cfg.wsel        <= cfg_data[pvqcd_pkg::WSEL_W-1:0];
        pvqcd_pkg::REG_NUM_EXPERTS:  cfg.num_experts <= cfg_data[pvqcd_pkg::EXPERT_W-1:0];
        pvqcd_pkg::REG_NUM_ROWS:     cfg.num_rows    <= cfg_data[pvqcd_pkg::DIM_W-1:0];
        pvqcd_pkg::REG_NUM_PAIRS:    cfg.num_pairs   <= cfg_data[pvqcd_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept, check coordinates, build the bit offset
  pvqcd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .func         (func),
    .write_addr   (write_addr),
    .write_re     (write_re),
    .write_im     (write_im),
    .expert_index (expert_index),
    .row_index    (row_index),
    .pair_index   (pair_index),
    .cfg          (cfg),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  // Queue decouples front stalls from back stalls
  pvqcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  // Back: store writes, code fetch, centroid lookup, result register
  pvqcd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .q_stat      (q_stat),
    .q_pop       (q_pop),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .code_value  (code_value),
    .centroid_re (centroid_re),
    .centroid_im (centroid_im)
  );

  `PVQCD_ASSERT_NOW(a_fail_zero, rsp_valid && (status != pvqcd_pkg::ST_OK), (code_value == '0) && (centroid_re == '0) && (centroid_im == '0), "failed beat carries nonzero payload")
  `PVQCD_ASSERT_NOW(a_stall_full, req_stall, q_stat.full, "request stalled while queue has room")
  `PVQCD_ASSERT_NEXT(a_push_fills, q_push && q_stat.empty, !q_stat.empty, "push into empty queue lost")

endmodule

/* test/vq_decode_checker.sv */
`timescale 1ns / 1ps

module vq_decode_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pvqcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pvqcd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           req_valid,
  input  logic                           req_stall,
  input  logic [pvqcd_pkg::FUNC_W-1:0]     func,
  input  logic [pvqcd_pkg::WADDR_W-1:0]    write_addr,
  input  logic [pvqcd_pkg::WORD_W-1:0]     write_re,
  input  logic [pvqcd_pkg::WORD_W-1:0]     write_im,
  input  logic [pvqcd_pkg::EXPERT_W-1:0]   expert_index,
  input  logic [pvqcd_pkg::DIM_W-1:0]      row_index,
  input  logic [pvqcd_pkg::DIM_W-1:0]      pair_index,
  input  logic                           rsp_valid,
  input  logic                           rsp_stall,
  input  logic [pvqcd_pkg::STATUS_W-1:0]   status,
  input  logic [pvqcd_pkg::CODE_W-1:0]     code_value,
  input  logic [pvqcd_pkg::WORD_W-1:0]     centroid_re,
  input  logic [pvqcd_pkg::WORD_W-1:0]     centroid_im,
  output int                             mismatches,
  output int                             pending
);
  import pvqcd_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CODE_W-1:0]   code;
    logic [WORD_W-1:0]   re;
    logic [WORD_W-1:0]   im;
  } reply_t;

  logic [7:0]        code_mem [0:CODE_STORE_BYTES-1];
  logic [WORD_W-1:0] cent_re  [0:CODEBOOK_ENTRIES-1];
  logic [WORD_W-1:0] cent_im  [0:CODEBOOK_ENTRIES-1];

  logic [WSEL_W-1:0]   cur_wsel;
  logic [EXPERT_W-1:0] cur_experts;
  logic [DIM_W-1:0]    cur_rows;
  logic [DIM_W-1:0]    cur_pairs;

  reply_t replies_due [$];
  int     fail_total = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // Apply one request beat to the shadow stores and work out its reply.
  task automatic predict_reply(input logic [FUNC_W-1:0] f, input logic [WADDR_W-1:0] a,
                               input logic [WORD_W-1:0] wre, input logic [WORD_W-1:0] wim,
                               input logic [EXPERT_W-1:0] e, input logic [DIM_W-1:0] r,
                               input logic [DIM_W-1:0] p, output reply_t rp);
    logic [63:0] lin;
    logic [63:0] bit_pos;
    logic [63:0] byte_pos;
    logic [3:0]  nbits;
    logic [2:0]  sh;
    logic        straddle;
    logic [15:0] window;
    logic [7:0]  mask;
    rp = '0;
    case (f)
      FUNC_WR_CODE: code_mem[a] = wre[7:0];
      FUNC_WR_CB: begin
        if (a < CODEBOOK_ENTRIES) begin
          cent_re[a[CB_ADDR_W-1:0]] = wre;
          cent_im[a[CB_ADDR_W-1:0]] = wim;
        end else begin
          rp.status = ST_RANGE;
        end
      end
      FUNC_DECODE: begin
        case (cur_wsel)
          WSEL_4:  nbits = 4'd4;
          WSEL_6:  nbits = 4'd6;
          default: nbits = 4'd8;
        endcase
        if (e >= cur_experts || r >= cur_rows || p >= cur_pairs) begin
          rp.status = ST_RANGE;
        end else begin
          // 64-bit target widens every operand before the products
          lin      = e * cur_rows * cur_pairs + r * cur_pairs + p;
          bit_pos  = lin * nbits;
          byte_pos = bit_pos >> 3;
          sh       = bit_pos[2:0];
          straddle = (nbits + sh) > 8;
          if (byte_pos >= CODE_STORE_BYTES ||
              (straddle && byte_pos + 1 >= CODE_STORE_BYTES)) begin
            rp.status = ST_PAST;
          end else begin
            window = {(straddle ? code_mem[byte_pos + 1] : 8'h00), code_mem[byte_pos]};
            window = window >> sh;
            mask   = 8'hFF >> (8 - nbits);
            // an 8-bit code always lands inside a 256-entry codebook
            rp.code = window[7:0] & mask;
            rp.re   = cent_re[rp.code];
            rp.im   = cent_im[rp.code];
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst) begin
      replies_due.delete();
      cur_wsel    = WSEL_RESET;
      cur_experts = '0;
      cur_rows    = '0;
      cur_pairs   = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH_SELECT: cur_wsel    = cfg_data[WSEL_W-1:0];
          REG_NUM_EXPERTS:  cur_experts = cfg_data[EXPERT_W-1:0];
          REG_NUM_ROWS:     cur_rows    = cfg_data[DIM_W-1:0];
          default:          cur_pairs   = cfg_data[DIM_W-1:0];
        endcase
      end
      if (rsp_valid && !rsp_stall) begin
        got = '{status, code_value, centroid_re, centroid_im};
        if (replies_due.size() == 0) begin
          $display("%0t: reply with none due: status %0d code %0h re %h im %h",
                   $time, got.status, got.code, got.re, got.im);
          fail_total++;
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fail_total++;
          end
          if (got.code !== want.code) begin
            $display("%0t: code_value expected %0h actual %0h", $time, want.code, got.code);
            fail_total++;
          end
          if (got.re !== want.re) begin
            $display("%0t: centroid_re expected %h actual %h", $time, want.re, got.re);
            fail_total++;
          end
          if (got.im !== want.im) begin
            $display("%0t: centroid_im expected %h actual %h", $time, want.im, got.im);
            fail_total++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        predict_reply(func, write_addr, write_re, write_im,
                      expert_index, row_index, pair_index, want);
        replies_due.push_back(want);
      end
    end
    mismatches <= fail_total;
    pending    <= replies_due.size();
  end

endmodule

/* test/tb_packed_vq_code_decoder.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the packed code decoder. The checker beside the
// block watches both channels, predicts each reply and compares it; this
// module only drives beats, configures the block and decides the outcome.
module tb_packed_vq_code_decoder;
  import pvqcd_pkg::*;

  // func 3 is unassigned in the block and must answer all zeros
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  // width select 3 is unassigned and behaves as 8-bit codes
  localparam logic [CFG_DATA_W-1:0] WSEL_SPARE_ALL_ONES = 16'hFFFF;
  // No beat on either channel and no register write for this long means the
  // block is hung. A correct run never gets near it: the random sender gaps
  // and receiver stalls are each drawn with a chance of at most 67 in 100,
  // so long unbroken stretches of them are very unlikely.
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 120;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  req_valid;
  logic                  req_stall;
  logic [FUNC_W-1:0]     func;
  logic [WADDR_W-1:0]    write_addr;
  logic [WORD_W-1:0]     write_re;
  logic [WORD_W-1:0]     write_im;
  logic [EXPERT_W-1:0]   expert_index;
  logic [DIM_W-1:0]      row_index;
  logic [DIM_W-1:0]      pair_index;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [CODE_W-1:0]     code_value;
  logic [WORD_W-1:0]     centroid_re;
  logic [WORD_W-1:0]     centroid_im;

  int mismatches;
  int pending;

  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  int          quiet_cycles  = 0;

  // Stimulus-side view of the configuration, used to aim decodes and to
  // load every code byte a decode will read before it is issued.
  logic [WSEL_W-1:0]   plan_wsel    = WSEL_RESET;
  logic [EXPERT_W-1:0] plan_experts = '0;
  logic [DIM_W-1:0]    plan_rows    = '0;
  logic [DIM_W-1:0]    plan_pairs   = '0;
  bit                  byte_loaded [0:CODE_STORE_BYTES-1];

  always #5 clk = ~clk;

  packed_vq_code_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .func         (func),
    .write_addr   (write_addr),
    .write_re     (write_re),
    .write_im     (write_im),
    .expert_index (expert_index),
    .row_index    (row_index),
    .pair_index   (pair_index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .code_value   (code_value),
    .centroid_re  (centroid_re),
    .centroid_im  (centroid_im)
  );

  vq_decode_checker decode_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .func         (func),
    .write_addr   (write_addr),
    .write_re     (write_re),
    .write_im     (write_im),
    .expert_index (expert_index),
    .row_index    (row_index),
    .pair_index   (pair_index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .code_value   (code_value),
    .centroid_re  (centroid_re),
    .centroid_im  (centroid_im),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  // Receiver back-pressure: redraw the stall at every falling edge.
  always @(negedge clk) begin
    rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
  end

  // Watchdog: count cycles without a beat or a register write.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_packed_vq_code_decoder: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [15:0] pick_below(input logic [15:0] count);
    logic [15:0] v;
    v = $urandom;
    // a zero count has no valid value; any value then tests the range check
    if (count != 0) v = $urandom_range(count - 1, 0);
    return v;
  endfunction

  // Drive one request beat. Enter and leave at a falling edge; hold the
  // payload until the beat is taken.
  task automatic put_beat(input logic [FUNC_W-1:0] f, input logic [WADDR_W-1:0] a,
                          input logic [WORD_W-1:0] wre, input logic [WORD_W-1:0] wim,
                          input logic [EXPERT_W-1:0] e, input logic [DIM_W-1:0] r,
                          input logic [DIM_W-1:0] p);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid    <= 1'b1;
    func         <= f;
    write_addr   <= a;
    write_re     <= wre;
    write_im     <= wim;
    expert_index <= e;
    row_index    <= r;
    pair_index   <= p;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_byte(input logic [WADDR_W-1:0] a, input logic [WORD_W-1:0] d);
    byte_loaded[a] = 1'b1;
    put_beat(FUNC_WR_CODE, a, d, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Issue a decode; first load the code byte it reads, and the one after it,
  // wherever they have never been written.
  task automatic decode_pair(input logic [EXPERT_W-1:0] e, input logic [DIM_W-1:0] r,
                             input logic [DIM_W-1:0] p);
    logic [63:0] lin;
    logic [63:0] first;
    logic [3:0]  nbits;
    int          k;
    case (plan_wsel)
      WSEL_4:  nbits = 4'd4;
      WSEL_6:  nbits = 4'd6;
      default: nbits = 4'd8;
    endcase
    if (e < plan_experts && r < plan_rows && p < plan_pairs) begin
      lin   = e * plan_rows * plan_pairs + r * plan_pairs + p;
      first = (lin * nbits) >> 3;
      for (k = 0; k < 2; k++) begin
        if (first + k < CODE_STORE_BYTES && !byte_loaded[first + k])
          load_byte(first + k, $urandom);
      end
    end
    put_beat(FUNC_DECODE, $urandom, $urandom, $urandom, e, r, p);
  endtask

  // Drop valid and hold off until every reply has come back.
  task automatic drain_replies();
    req_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
  endtask

  // Reconfigure only with the block empty.
  task automatic configure(input logic [CFG_DATA_W-1:0] sel, input logic [CFG_DATA_W-1:0] ne,
                           input logic [CFG_DATA_W-1:0] nr, input logic [CFG_DATA_W-1:0] np);
    drain_replies();
    write_reg(REG_WIDTH_SELECT, sel);
    write_reg(REG_NUM_EXPERTS, ne);
    write_reg(REG_NUM_ROWS, nr);
    write_reg(REG_NUM_PAIRS, np);
    cfg_we <= 1'b0;
    @(negedge clk);
    plan_wsel    = sel[WSEL_W-1:0];
    plan_experts = ne[EXPERT_W-1:0];
    plan_rows    = nr;
    plan_pairs   = np;
  endtask

  task automatic run_random(input int n, input bit pause_midway);
    int                  k;
    int                  pick;
    logic [EXPERT_W-1:0] e;
    logic [DIM_W-1:0]    r;
    logic [DIM_W-1:0]    p;
    logic [WADDR_W-1:0]  a;
    for (k = 0; k < n; k++) begin
      // let the pipeline run dry once with the sender held back
      if (pause_midway && k == n / 2) drain_replies();
      pick = $urandom_range(99);
      if (pick < 55) begin
        e = pick_below(plan_experts);
        r = pick_below(plan_rows);
        p = pick_below(plan_pairs);
        if ($urandom_range(2) == 0) begin
          // pull large shapes back toward the start of the store
          e = '0;
          r = pick_below(plan_rows < 2 ? plan_rows : 16'd2);
        end
        decode_pair(e, r, p);
      end else if (pick < 63) begin
        // each coordinate at its last valid value or one past it
        e = plan_experts - $urandom_range(1, 0);
        r = plan_rows - $urandom_range(1, 0);
        p = plan_pairs - $urandom_range(1, 0);
        decode_pair(e, r, p);
      end else if (pick < 70) begin
        decode_pair($urandom, $urandom, $urandom);
      end else if (pick < 82) begin
        a = $urandom;
        if ($urandom_range(1)) a[15:8] = '0;
        load_byte(a, $urandom);
      end else if (pick < 94) begin
        // half land in the codebook, the rest mostly beyond it
        a = $urandom;
        if ($urandom_range(1)) a[15:8] = '0;
        put_beat(FUNC_WR_CB, a, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        put_beat(FUNC_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int k;
    int ph;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    req_valid    = 1'b0;
    func         = '0;
    write_addr   = '0;
    write_re     = '0;
    write_im     = '0;
    expert_index = '0;
    row_index    = '0;
    pair_index   = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset shape has every dimension at zero: decodes are out of range.
    decode_pair('0, '0, '0);
    decode_pair('1, '1, '1);
    put_beat(FUNC_SPARE, '1, '1, '1, '1, '1, '1);
    // codebook writes just past the end and at the top of the address range
    put_beat(FUNC_WR_CB, 16'd256, '1, '1, '0, '0, '0);
    put_beat(FUNC_WR_CB, 16'hFFFF, '1, '1, '0, '0, '0);
    // extreme entries and bytes at both ends of the store
    put_beat(FUNC_WR_CB, 16'd0, '0, '1, '1, '1, '1);
    put_beat(FUNC_WR_CB, 16'd255, '1, '0, '0, '0, '0);
    load_byte(16'hFFFF, '1);
    load_byte(16'h0000, '0);

    // Fill the rest of the codebook so any code finds a defined centroid.
    for (k = 1; k < CODEBOOK_ENTRIES - 1; k++)
      put_beat(FUNC_WR_CB, k, $urandom, $urandom, $urandom, $urandom, $urandom);

    // Largest shape, 6-bit codes (upper data bits set and masked off).
    configure(16'hFFFD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    decode_pair(10'd0, 16'd0, 16'd0);
    decode_pair(10'd0, 16'd0, 16'd1);       // code straddles bytes 0 and 1
    decode_pair(10'd0, 16'd1, 16'd21845);   // whole code in the last byte
    decode_pair(10'd0, 16'd1, 16'd21846);   // second byte past the store
    decode_pair(10'd1022, 16'd65534, 16'd65534);
    decode_pair(10'd1023, 16'd0, 16'd0);
    decode_pair(10'd0, 16'd65535, 16'd0);
    decode_pair(10'd0, 16'd0, 16'd65535);

    // Unassigned width select behaves as 8-bit codes.
    configure(WSEL_SPARE_ALL_ONES, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    decode_pair(10'd0, 16'd1, 16'd0);       // last byte, code 255
    decode_pair(10'd0, 16'd1, 16'd1);       // first byte past the store

    configure(WSEL_4, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    decode_pair(10'd0, 16'd0, 16'd1);
    decode_pair(10'd0, 16'd2, 16'd1);       // upper nibble of the last byte
    decode_pair(10'd0, 16'd2, 16'd2);

    // Random phases: each with its own shape and one of four idling patterns.
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       configure(WSEL_8, 16'd0, 16'd7, 16'd9);
        1:       configure(WSEL_4, 16'd3, 16'd5, 16'd7);
        2:       configure(WSEL_6, 16'd2, 16'd3, 16'd11);
        3:       configure(WSEL_8, 16'd4, 16'd4, 16'd4);
        4:       configure(WSEL_SPARE_ALL_ONES, 16'd1, 16'd1, 16'd1);
        5:       configure(WSEL_6, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        6:       configure(WSEL_4, 16'd6, 16'd1, 16'd40);
        default: configure($urandom_range(3), $urandom_range(8, 1),
                           $urandom_range(8, 1), $urandom_range(8, 1));
      endcase
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          rsp_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 67;
          rsp_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          rsp_stall_pct = 67;
        end
        default: begin
          send_idle_pct = 18;
          rsp_stall_pct = 18;
        end
      endcase
      run_random(PHASE_BEATS, ph % 2 == 1);
    end

    // Wait out the last replies, then watch a little longer for strays.
    drain_replies();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_packed_vq_code_decoder: PASS");
    end else begin
      $display("tb_packed_vq_code_decoder: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/pvqcd_pkg.sv
hw/rtl/pvqcd_ram.sv
hw/rtl/pvqcd_front.sv
hw/rtl/pvqcd_queue.sv
hw/rtl/pvqcd_back.sv
hw/rtl/packed_vq_code_decoder.sv
test/vq_decode_checker.sv
test/tb_packed_vq_code_decoder.sv
